// ===== src/sclp_pkg.sv =====
`default_nettype none
package sclp_pkg;

  localparam int LINE_SIZE_DEF   = 64;
  localparam int FRAC_DIGITS_DEF = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_FREQ   = 3'd3,
    CMD_SECTOR = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_CMD   = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CFG_FREQ_MIN = 1'b0,
    CFG_FREQ_MAX = 1'b1
  } cfg_idx_t;

  // Front-to-back queue entry: a line-end event, a line overflow or a stored byte.
  typedef struct packed {
    logic       line_end;
    logic       full;
    logic [7:0] data;
  } tok_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB);
  endfunction

  function automatic logic is_cspace(input logic [7:0] c);
    return is_blank(c) || (c >= 8'h0A && c <= 8'h0D);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage
`default_nettype wire

// ===== src/sclp_front.sv =====
`default_nettype none
module sclp_front #(
  parameter int LINE_SIZE = sclp_pkg::LINE_SIZE_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire [7:0]           in_rx_byte,
  output logic                q_valid,
  input  wire                 q_ready,
  output sclp_pkg::tok_t      q_tok
);
  import sclp_pkg::*;

  localparam int CW = $clog2(LINE_SIZE);

  logic [CW-1:0] count_r, count_nxt;
  logic          is_eol, acc, keep, push, pop;
  tok_t          tok;
  tok_t          fifo_r [2];
  logic          wr_sel_r, rd_sel_r;
  logic [1:0]    fill_r;

  assign in_ready = (fill_r != 2'd2);
  assign acc      = in_valid && in_ready;
  assign push     = acc && keep;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (fill_r != 2'd0);
  assign q_tok    = fifo_r[rd_sel_r];
  assign is_eol   = (in_rx_byte == CH_CR) || (in_rx_byte == CH_LF);

  // Classify: byte, line end, or overflow. An empty-line end is dropped.
  always_comb begin
    count_nxt     = count_r;
    tok.line_end  = 1'b0;
    tok.full      = 1'b0;
    tok.data      = in_rx_byte;
    keep          = 1'b0;
    if (in_valid) begin
      if (is_eol) begin
        keep         = (count_r != '0);
        tok.line_end = 1'b1;
        count_nxt    = '0;
      end else if (count_r >= CW'(LINE_SIZE - 1)) begin
        keep      = 1'b1;
        tok.full  = 1'b1;
        count_nxt = '0;
      end else begin
        keep      = 1'b1;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_sel_r <= 1'b0;
      rd_sel_r <= 1'b0;
      fill_r   <= '0;
    end else begin
      if (acc) count_r <= count_nxt;
      if (push) wr_sel_r <= !wr_sel_r;
      if (pop) rd_sel_r <= !rd_sel_r;
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  // Two-entry queue toward the back end.
  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_sel_r] <= tok;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_eol) |=> (count_r == '0))
    else $error("count not cleared at line end");
  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(LINE_SIZE - 1))
    else $error("line count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && q_tok.full) |-> !q_tok.line_end)
    else $error("conflicting token kinds");
  assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= 2'd2)
    else $error("queue overflow");

endmodule
`default_nettype wire

// ===== src/sclp_back.sv =====
`default_nettype none
module sclp_back #(
  parameter int LINE_SIZE   = sclp_pkg::LINE_SIZE_DEF,
  parameter int FRAC_DIGITS = sclp_pkg::FRAC_DIGITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   q_valid,
  output logic                  q_ready,
  input  sclp_pkg::tok_t        q_tok,
  input  wire signed [31:0]     freq_min,
  input  wire signed [31:0]     freq_max,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [2:0]            out_command,
  output logic [1:0]            out_status,
  output logic signed [31:0]    out_freq_value,
  output logic [2:0]            out_sector_value
);
  import sclp_pkg::*;

  localparam int CW  = $clog2(LINE_SIZE);
  localparam int FW  = $clog2(10 ** FRAC_DIGITS + 1) + 1;
  localparam int FDW = $clog2(FRAC_DIGITS + 1);

  // Keyword slot value while the captured text awaits its decision.
  localparam logic [2:0] KW_DECIDE = 3'd7;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_TRIM, S_LEAD, S_SCAN, S_FDIV, S_DONE
  } state_t;

  // Argument scanner phases.
  typedef enum logic [2:0] {
    A_WS, A_SIGN, A_INT, A_FRAC, A_TAIL
  } aph_t;

  logic [7:0]    mem [LINE_SIZE];
  logic [CW-1:0] wr_ptr_r;
  logic [CW-1:0] rd_addr;
  logic [7:0]    rd_q;

  state_t          st_r;
  aph_t            aph_r;
  logic [CW:0]     n_r, s_r, p_r, cnt_r;
  logic            neg_r, seen_r, bad_r, rd_pend_r;
  logic [2:0]      kw_r;       // command code of the keyword being parsed
  logic [32:0]     ip_r;
  logic [FW-1:0]   fp_r, scale_r;
  logic [FDW-1:0]  fd_r;
  logic [FW+8:0]   rem_r;
  logic [8:0]      quo_r;
  logic [3:0]      div_i_r;
  logic [7:0]      k0_r, k1_r, k2_r, k3_r, k4_r, k5_r, k6_r;
  logic [3:0]      ki_r;

  logic [2:0]      cmd_r;
  logic [1:0]      sts_r;
  logic [31:0]     fv_r;
  logic [2:0]      sec_r;
  logic            ov_r;

  assign out_valid        = ov_r;
  assign out_command      = cmd_r;
  assign out_status       = sts_r;
  assign out_freq_value   = fv_r;
  assign out_sector_value = sec_r;

  // A waiting result holds back only transactions that produce a result.
  assign q_ready = (st_r == S_IDLE) && (!ov_r || (!q_tok.line_end && !q_tok.full));

  always_comb begin
    rd_addr = p_r[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready && !q_tok.line_end && !q_tok.full)
      mem[wr_ptr_r] <= q_tok.data;
    rd_q <= mem[rd_addr];
  end

  logic [7:0] c;
  assign c = rd_q;

  logic [35:0] ip10;
  logic [FW+8:0] trial;
  assign ip10  = {ip_r, 3'b0} + {2'b0, ip_r, 1'b0} + 36'(c - 8'h30);
  assign trial = {rem_r[FW+7:0], 1'b0};

  logic [32:0] ipc;
  assign ipc = (ip_r > 33'h100000000) ? 33'h100000000 : ip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      ov_r      <= 1'b0;
      wr_ptr_r  <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            if (q_tok.full) begin
              cmd_r <= CMD_NONE; sts_r <= ST_FULL; fv_r <= '0; sec_r <= '0;
              ov_r <= 1'b1; wr_ptr_r <= '0;
            end else if (q_tok.line_end) begin
              cnt_r <= {1'b0, wr_ptr_r};
              wr_ptr_r <= '0;
              n_r <= '0; p_r <= '0; rd_pend_r <= 1'b1;
              st_r <= S_FIND;
            end else begin
              wr_ptr_r <= wr_ptr_r + 1'b1;
            end
          end
        end
        // Find the zero byte or the line end.
        S_FIND: begin
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
          end else if (n_r == cnt_r || c == CH_NUL) begin
            st_r <= S_TRIM; p_r <= n_r - 1'b1; rd_pend_r <= 1'b1;
          end else begin
            n_r <= n_r + 1'b1; p_r <= n_r + 2'd2 - 1'b1; rd_pend_r <= 1'b1;
          end
        end
        // Drop trailing blanks.
        S_TRIM: begin
          if (n_r == '0) begin
            st_r <= S_LEAD; s_r <= '0; p_r <= '0; rd_pend_r <= 1'b1;
          end else if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
          end else if (is_blank(c)) begin
            n_r <= n_r - 1'b1; p_r <= n_r - 2'd2; rd_pend_r <= 1'b1;
          end else begin
            st_r <= S_LEAD; s_r <= '0; p_r <= '0; rd_pend_r <= 1'b1;
          end
        end
        // Skip leading blanks.
        S_LEAD: begin
          if (s_r == n_r) begin
            cmd_r <= CMD_NONE; sts_r <= ST_OK; fv_r <= '0; sec_r <= '0;
            st_r <= S_DONE;
          end else if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
          end else if (is_blank(c)) begin
            s_r <= s_r + 1'b1; p_r <= s_r + 1'b1; rd_pend_r <= 1'b1;
          end else begin
            ki_r <= '0; p_r <= s_r;
            st_r <= S_SCAN; aph_r <= A_WS;
            kw_r <= CMD_NONE; ip_r <= '0; fp_r <= '0; scale_r <= FW'(1); fd_r <= '0;
            neg_r <= 1'b0; seen_r <= 1'b0; bad_r <= 1'b0;
            rd_pend_r <= 1'b1;
          end
        end
        // Capture first up to seven text bytes, then scan argument.
        S_SCAN: begin
          if (rd_pend_r) begin
            rd_pend_r <= 1'b0;
          end else if (kw_r == CMD_NONE) begin
            if (p_r != n_r) begin
              case (ki_r)
                4'd0: k0_r <= c;
                4'd1: k1_r <= c;
                4'd2: k2_r <= c;
                4'd3: k3_r <= c;
                4'd4: k4_r <= c;
                4'd5: k5_r <= c;
                4'd6: k6_r <= c;
                default: ;
              endcase
            end
            if (p_r == n_r || ki_r == 4'd6) begin
              // decide in final stage below
              ki_r <= 4'd7;
              kw_r <= KW_DECIDE;
            end else begin
              ki_r <= ki_r + 1'b1; p_r <= p_r + 1'b1; rd_pend_r <= 1'b1;
            end
          end else if (kw_r == KW_DECIDE) begin
            logic [CW:0] ln;
            ln = n_r - s_r;
            if (ln == 5 && {k0_r,k1_r,k2_r,k3_r,k4_r} == "start") begin
              cmd_r <= CMD_START; sts_r <= ST_OK; fv_r <= '0; sec_r <= '0;
              st_r <= S_DONE;
            end else if (ln == 4 && {k0_r,k1_r,k2_r,k3_r} == "stop") begin
              cmd_r <= CMD_STOP; sts_r <= ST_OK; fv_r <= '0; sec_r <= '0;
              st_r <= S_DONE;
            end else if (ln >= 5 && {k0_r,k1_r,k2_r,k3_r} == "freq" &&
                         is_blank(k4_r)) begin
              kw_r <= CMD_FREQ; p_r <= s_r + 3'd4; rd_pend_r <= 1'b1;
            end else if (ln >= 7 && {k0_r,k1_r,k2_r,k3_r,k4_r,k5_r} == "sector"
                         && is_blank(k6_r)) begin
              kw_r <= CMD_SECTOR; p_r <= s_r + 3'd6; rd_pend_r <= 1'b1;
            end else begin
              cmd_r <= CMD_NONE; sts_r <= ST_CMD; fv_r <= '0; sec_r <= '0;
              st_r <= S_DONE;
            end
          end else begin
            // Argument scan, one byte per read.
            logic adv;
            adv = 1'b0;
            if (p_r == n_r) begin
              if (kw_r == CMD_FREQ) begin
                if (!seen_r || bad_r) begin
                  cmd_r <= CMD_NONE; sts_r <= ST_CMD; fv_r <= '0; sec_r <= '0;
                  st_r <= S_DONE;
                end else begin
                  quo_r <= '0; div_i_r <= 4'd9;
                  rem_r <= (FW+9)'(fp_r);
                  st_r <= S_FDIV;
                end
              end else begin
                if (!seen_r) begin
                  sts_r <= ST_CMD; sec_r <= '0;
                  cmd_r <= CMD_NONE;
                end else if (bad_r || ip_r > 33'd6 || (neg_r && ip_r != '0)) begin
                  sts_r <= ST_RANGE; sec_r <= '0; cmd_r <= CMD_NONE;
                end else begin
                  sts_r <= ST_OK; sec_r <= ip_r[2:0]; cmd_r <= CMD_SECTOR;
                end
                fv_r <= '0; st_r <= S_DONE;
              end
            end else begin
              adv = 1'b1;
              case (aph_r)
                A_WS: begin
                  if (!is_cspace(c)) begin
                    adv = 1'b0; aph_r <= A_SIGN;
                  end
                end
                A_SIGN: begin
                  if (c == CH_PLUS || c == CH_MINUS) begin
                    neg_r <= (c == CH_MINUS);
                  end else adv = 1'b0;
                  aph_r <= A_INT;
                end
                A_INT: begin
                  if (is_digit(c)) begin
                    if (kw_r == CMD_FREQ) begin
                      // saturate at 2^32, the clamp applied at the end
                      if (ip_r < 33'h100000000)
                        ip_r <= (ip10 > 36'h100000000) ? 33'h100000000 : ip10[32:0];
                    end else if (ip_r < 33'd1000) ip_r <= ip10[32:0];
                    seen_r <= 1'b1;
                  end else if (c == CH_POINT && kw_r == CMD_FREQ) begin
                    aph_r <= A_FRAC;
                  end else begin
                    adv = 1'b0; aph_r <= A_TAIL;
                  end
                end
                A_FRAC: begin
                  if (is_digit(c)) begin
                    if (fd_r < FDW'(FRAC_DIGITS)) begin
                      fp_r <= FW'({fp_r, 3'b0} + {fp_r, 1'b0} + FW'(c - 8'h30));
                      scale_r <= FW'({scale_r, 3'b0} + {scale_r, 1'b0});
                      fd_r <= fd_r + 1'b1;
                    end
                    seen_r <= 1'b1;
                  end else begin
                    adv = 1'b0; aph_r <= A_TAIL;
                  end
                end
                A_TAIL: begin
                  if (!is_blank(c)) bad_r <= 1'b1;
                end
                default: ;
              endcase
              if (adv) begin
                p_r <= p_r + 1'b1; rd_pend_r <= 1'b1;
              end
            end
          end
        end
        // Restoring divide: floor(fp*256/scale), one quotient bit a cycle.
        S_FDIV: begin
          if (div_i_r != '0) begin
            logic [FW+8:0] t;
            t = (div_i_r == 4'd9) ? rem_r : trial;
            if (div_i_r == 4'd9) begin
              if (t >= (FW+9)'(scale_r)) begin
                rem_r <= t - (FW+9)'(scale_r); quo_r <= 9'd1;
              end else begin
                rem_r <= t; quo_r <= 9'd0;
              end
            end else if (t >= (FW+9)'(scale_r)) begin
              rem_r <= t - (FW+9)'(scale_r); quo_r <= {quo_r[7:0], 1'b1};
            end else begin
              rem_r <= t; quo_r <= {quo_r[7:0], 1'b0};
            end
            div_i_r <= div_i_r - 1'b1;
          end else begin
            logic [40:0] m;
            logic signed [32:0] v;
            m = {ipc, 8'h00} + 41'(quo_r);
            if (neg_r) begin
              if (m > 41'h80000000) m = 41'h80000000;
              v = -$signed({1'b0, m[31:0]});
              if (m == 41'h80000000) v = -33'sh80000000;
            end else begin
              if (m > 41'h7FFFFFFF) m = 41'h7FFFFFFF;
              v = $signed({1'b0, m[31:0]});
            end
            if (v < 33'(freq_min) || v > 33'(freq_max)) begin
              cmd_r <= CMD_NONE; sts_r <= ST_RANGE; fv_r <= '0;
            end else begin
              cmd_r <= CMD_FREQ; sts_r <= ST_OK; fv_r <= v[31:0];
            end
            sec_r <= '0; st_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!ov_r) begin
            ov_r <= 1'b1; st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_command != CMD_NONE) |-> (out_status == ST_OK))
    else $error("command with error status");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !q_ready)
    else $error("queue taken while decoding");

endmodule
`default_nettype wire

// ===== src/serial_command_line_parser_unit.sv =====
`default_nettype none
// Serial command line parser: takes one received byte per transaction and
// returns one result per completed line (start, stop, freq, sector, empty)
// or per line overflow. A byte enters a two-entry queue and is written to
// the line memory when the decoder takes it from the queue. A line end
// starts a decode that reads the line memory byte by byte: one pass up to
// the line end or zero byte, then the trailing blanks, leading blanks, first
// seven text bytes and the argument once more, plus a fraction divide. While
// a line decodes the queue fills and then stalls the input; a result waiting
// on out_ready holds back only the next line end or overflow, while plain
// bytes keep flowing.
module serial_command_line_parser_unit #(
  parameter int LINE_SIZE   = sclp_pkg::LINE_SIZE_DEF,
  parameter int FRAC_DIGITS = sclp_pkg::FRAC_DIGITS_DEF
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire [7:0]         in_rx_byte,
  output logic              out_valid,
  input  wire               out_ready,
  output logic [2:0]        out_command,
  output logic [1:0]        out_status,
  output logic signed [31:0] out_freq_value,
  output logic [2:0]        out_sector_value,
  input  wire               cfg_we,
  input  wire [0:0]         cfg_index,
  input  wire [31:0]        cfg_data
);
  import sclp_pkg::*;

  logic signed [31:0] fmin_r, fmax_r;
  logic q_valid, q_ready;
  tok_t q_tok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmin_r <= 32'sd0;
      fmax_r <= 32'sd256000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FREQ_MIN: fmin_r <= cfg_data;
        CFG_FREQ_MAX: fmax_r <= cfg_data;
        default: ;
      endcase
    end
  end

  sclp_front #(.LINE_SIZE(LINE_SIZE)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_rx_byte,
    .q_valid, .q_ready, .q_tok
  );

  sclp_back #(.LINE_SIZE(LINE_SIZE), .FRAC_DIGITS(FRAC_DIGITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_tok,
    .freq_min(fmin_r), .freq_max(fmax_r),
    .out_valid, .out_ready, .out_command, .out_status,
    .out_freq_value, .out_sector_value
  );

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
  import sclp_pkg::*;

  localparam int LINE_MAX = LINE_SIZE_DEF - 1;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic [2:0]         command;
    logic [1:0]         status;
    logic signed [31:0] freq_value;
    logic [2:0]         sector_value;
  } line_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] out_command;
  logic [1:0] out_status;
  logic signed [31:0] out_freq_value;
  logic [2:0] out_sector_value;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = CFG_FREQ_MIN;
  logic [31:0] cfg_data = '0;

  serial_command_line_parser_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_command(out_command), .out_status(out_status),
    .out_freq_value(out_freq_value), .out_sector_value(out_sector_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [7:0] line_bytes [LINE_SIZE_DEF];
  int unsigned held_count;
  logic signed [63:0] lo_limit, hi_limit;

  logic [7:0] pending_bytes [$];
  line_result_t expected_results [$];

  int send_idle_pct, recv_idle_pct;
  int hold_off_cycles;
  int mismatches, result_count, item_count, quiet_cycles;
  bit timed_out;

  function automatic bit blank_ch(logic [7:0] c);
    return c == CH_SP || c == CH_TAB;
  endfunction

  function automatic bit space_ch(logic [7:0] c);
    return blank_ch(c) || (c >= 8'h0A && c <= 8'h0D);
  endfunction

  function automatic bit digit_ch(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit word_at(int unsigned p, string w);
    for (int i = 0; i < w.len(); i++)
      if (line_bytes[p + i] != w[i]) return 0;
    return 1;
  endfunction

  function automatic status_t scan_freq(int unsigned p, int unsigned n,
                                        output logic signed [63:0] val);
    logic [63:0] ip, fp, scale, mag;
    int unsigned fd;
    bit neg, seen;
    ip = 0; fp = 0; scale = 1; fd = 0; neg = 0; seen = 0; val = 0;
    while (p < n && space_ch(line_bytes[p])) p++;
    if (p < n && (line_bytes[p] == CH_PLUS || line_bytes[p] == CH_MINUS)) begin
      neg = line_bytes[p] == CH_MINUS;
      p++;
    end
    while (p < n && digit_ch(line_bytes[p])) begin
      if (ip < 64'h1_0000_0000) ip = ip * 10 + (line_bytes[p] - "0");
      seen = 1;
      p++;
    end
    if (p < n && line_bytes[p] == CH_POINT) begin
      p++;
      while (p < n && digit_ch(line_bytes[p])) begin
        if (fd < FRAC_DIGITS_DEF) begin
          fp = fp * 10 + (line_bytes[p] - "0");
          scale = scale * 10;
          fd++;
        end
        seen = 1;
        p++;
      end
    end
    if (!seen) return ST_CMD;
    while (p < n && blank_ch(line_bytes[p])) p++;
    if (p != n) return ST_CMD;
    if (ip > 64'h1_0000_0000) ip = 64'h1_0000_0000;
    mag = ip * 256 + (fp * 256) / scale;
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      val = -$signed(mag);
    end else begin
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      val = $signed(mag);
    end
    return ST_OK;
  endfunction

  function automatic status_t scan_sector(int unsigned p, int unsigned n,
                                          output int unsigned sec);
    int unsigned acc;
    bit neg, seen;
    acc = 0; neg = 0; seen = 0; sec = 0;
    while (p < n && space_ch(line_bytes[p])) p++;
    if (p < n && (line_bytes[p] == CH_PLUS || line_bytes[p] == CH_MINUS)) begin
      neg = line_bytes[p] == CH_MINUS;
      p++;
    end
    while (p < n && digit_ch(line_bytes[p])) begin
      if (acc < 1000) acc = acc * 10 + (line_bytes[p] - "0");
      seen = 1;
      p++;
    end
    if (!seen) return ST_CMD;
    if (neg && acc != 0) acc = 1000;
    while (p < n && blank_ch(line_bytes[p])) p++;
    if (p != n || acc > 6) return ST_RANGE;
    sec = acc;
    return ST_OK;
  endfunction

  function automatic line_result_t decode_held_line();
    line_result_t r;
    int unsigned n, s, len, sec;
    logic signed [63:0] fv;
    status_t st;
    r = '0; n = 0; s = 0; sec = 0; fv = 0;
    while (n < held_count && line_bytes[n] != CH_NUL) n++;
    while (n > 0 && blank_ch(line_bytes[n - 1])) n--;
    while (s < n && blank_ch(line_bytes[s])) s++;
    len = n - s;
    if (len == 0) begin
      r.status = ST_OK;
    end else if (len == 5 && word_at(s, "start")) begin
      r.command = CMD_START;
    end else if (len == 4 && word_at(s, "stop")) begin
      r.command = CMD_STOP;
    end else if (len >= 5 && word_at(s, "freq") && blank_ch(line_bytes[s + 4])) begin
      st = scan_freq(s + 4, n, fv);
      if (st == ST_OK && (fv < lo_limit || fv > hi_limit)) st = ST_RANGE;
      r.status = st;
      if (st == ST_OK) begin
        r.command = CMD_FREQ;
        r.freq_value = fv[31:0];
      end
    end else if (len >= 7 && word_at(s, "sector") && blank_ch(line_bytes[s + 6])) begin
      st = scan_sector(s + 6, n, sec);
      r.status = st;
      if (st == ST_OK) begin
        r.command = CMD_SECTOR;
        r.sector_value = sec[2:0];
      end
    end else begin
      r.status = ST_CMD;
    end
    return r;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    line_result_t r;
    if (b == CH_CR || b == CH_LF) begin
      if (held_count == 0) return;
      expected_results.push_back(decode_held_line());
      held_count = 0;
    end else if (held_count >= LINE_MAX) begin
      held_count = 0;
      r = '0;
      r.status = ST_FULL;
      expected_results.push_back(r);
    end else begin
      line_bytes[held_count] = b;
      held_count++;
    end
  endfunction

  // driver: predict at acceptance, then present the next byte
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_byte(in_rx_byte);
        item_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_rx_byte <= pending_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    line_result_t exp_r;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result cmd=%0d st=%0d", out_command,
                                         out_status);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_command !== exp_r.command || out_status !== exp_r.status ||
              out_freq_value !== exp_r.freq_value ||
              out_sector_value !== exp_r.sector_value) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected cmd=%0d st=%0d freq=%0d sec=%0d, got cmd=%0d st=%0d freq=%0d sec=%0d",
                       exp_r.command, exp_r.status, exp_r.freq_value, exp_r.sector_value,
                       out_command, out_status, out_freq_value, out_sector_value);
          end
        end
      end
      if (hold_off_cycles > 0) begin
        hold_off_cycles--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || hold_off_cycles > 0)
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("watchdog: no progress, %0d results still expected",
                 expected_results.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endtask

  task automatic add_line(string s);
    add_text(s);
    pending_bytes.push_back($urandom_range(1) ? CH_CR : CH_LF);
  endtask

  task automatic write_limits(logic signed [31:0] lo, logic signed [31:0] hi);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_FREQ_MIN;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= CFG_FREQ_MAX;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    lo_limit = lo;
    hi_limit = hi;
  endtask

  task automatic drain();
    while (pending_bytes.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    // a trailing byte may still be in flight even with nothing expected
    repeat (3 * LINE_SIZE_DEF + 40) @(posedge clk);
  endtask

  function automatic string rand_digits(int unsigned cnt);
    string s;
    s = "";
    for (int i = 0; i < cnt; i++) s = {s, string'(8'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rand_blanks();
    string s;
    s = "";
    repeat ($urandom_range(2)) s = {s, $urandom_range(1) ? " " : "\t"};
    return s;
  endfunction

  function automatic string rand_number();
    string s;
    int k;
    s = "";
    k = $urandom_range(9);
    if (k == 0) s = "+";
    else if (k < 4) s = "-";
    if ($urandom_range(7) == 0) s = {s, rand_digits($urandom_range(11, 14))};
    else s = {s, rand_digits($urandom_range(0, 6))};
    if ($urandom_range(1)) s = {s, ".", rand_digits($urandom_range(0, 6))};
    return s;
  endfunction

  task automatic add_random_lines(int unsigned items);
    int unsigned target;
    string s;
    target = pending_bytes.size() + items;
    while (pending_bytes.size() < target) begin
      s = rand_blanks();
      case ($urandom_range(11))
        0: s = {s, "start"};
        1: s = {s, "stop"};
        2, 3, 4: s = {s, "freq", $urandom_range(1) ? " " : "\t", rand_blanks(), rand_number()};
        5, 6: begin
          s = {s, "sector ", rand_blanks()};
          case ($urandom_range(4))
            0: s = {s, "-"};
            1: s = {s, "+"};
            default: ;
          endcase
          s = {s, rand_digits($urandom_range(0, 2))};
        end
        7: s = {s, "freq ", $urandom_range(1) ? "1e3" : "0x1A"};
        8: repeat ($urandom_range(1, 70)) s = {s, string'(8'($urandom_range(32, 126)))};
        9: begin
          // raw noise, including zero bytes and high bit
          repeat ($urandom_range(1, 20)) pending_bytes.push_back(8'($urandom_range(255)));
        end
        10: s = {s, "sector 3", $urandom_range(1) ? "x" : " 1"};
        default: s = {s, "freq ", rand_number(), $urandom_range(1) ? "z" : ""};
      endcase
      s = {s, rand_blanks()};
      add_line(s);
    end
  endtask

  initial begin
    held_count = 0;
    lo_limit = 0;
    hi_limit = 256000;
    mismatches = 0; result_count = 0; item_count = 0; quiet_cycles = 0;
    hold_off_cycles = 0;
    send_idle_pct = 12;
    recv_idle_pct = 71;
    foreach (line_bytes[i]) line_bytes[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed lines under reset limits
    add_line("start");
    add_line(" \tstop\t ");
    add_line("freq 1000");
    add_line("freq\t-0.5");
    add_line("freq 999.99999");
    add_line("freq 1001");
    add_line("freq \v+12.");
    add_line("freq .");
    add_line("freq 1e3");
    add_line("sector 6");
    add_line("sector -0");
    add_line("sector 7");
    add_line("sector -1");
    add_line("sector");
    add_line("stop");
    add_text("start");
    pending_bytes.push_back(CH_NUL);
    add_line("junk");
    add_line("   ");
    add_line("bogus");
    pending_bytes.push_back(CH_LF);
    repeat (LINE_MAX + 1) pending_bytes.push_back(8'hFF);
    add_line("start");
    // hold the receiver off so the block backs up
    hold_off_cycles = 600;
    drain();

    write_limits(32'sh8000_0000, 32'sh7FFF_FFFF);
    add_line("freq -99999999999");
    add_line("freq 99999999999.9");
    add_line("freq -8388608");
    add_random_lines(550);
    drain();

    send_idle_pct = 71;
    recv_idle_pct = 12;
    write_limits(-32'sd25600, 32'sd51200);
    add_random_lines(550);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_limits(32'sd100, -32'sd100);
    add_random_lines(250);
    drain();
    write_limits(32'sh8000_0000, 32'sh7FFF_FFFF);
    add_random_lines(250);
    drain();

    $display("Covered %0d bytes and %0d line results over four limit settings.",
             item_count, result_count);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
